FILE: rtl/core/lcs_pkg.sv
// Shared types, constants and widths of the lane centroid steering block.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package lcs_pkg;

  // Longest scan row that is measured; further pixels only flag an overflow.
  localparam int MAX_WIDTH = 1024;

  // Column counter saturates at MAX_WIDTH, so it must hold that value.
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  // Widest column index and centroid.
  localparam int COL_W = $clog2(MAX_WIDTH);
  // Sum of all column indexes of one row.
  localparam int SUM_W = $clog2(MAX_WIDTH * (MAX_WIDTH - 1) / 2 + 1);
  // Divider step counter.
  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  // Field widths of the configuration and result.
  localparam int PIX_W = 8;
  localparam int XCOL_W = 10;
  localparam int OFS_W = 11;
  localparam int CMP_W = (CNT_W > XCOL_W) ? CNT_W : XCOL_W;
  localparam int LANE_W = (COL_W > XCOL_W) ? COL_W : XCOL_W;
  localparam logic [XCOL_W-1:0] XCOL_MAX = '1;

  // Row queue between the accumulator and the division back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_THRESHOLD_LOW  = 3'd0,
    REG_THRESHOLD_HIGH = 3'd1,
    REG_SPLIT_COLUMN   = 3'd2,
    REG_CAMERA_CENTER  = 3'd3,
    REG_DEADBAND       = 3'd4
  } reg_index_t;

  localparam logic [PIX_W-1:0]  THRESHOLD_LOW_RESET  = 8'd210;
  localparam logic [PIX_W-1:0]  THRESHOLD_HIGH_RESET = 8'd255;
  localparam logic [XCOL_W-1:0] SPLIT_COLUMN_RESET   = 10'd294;
  localparam logic [XCOL_W-1:0] CAMERA_CENTER_RESET  = 10'd294;
  localparam logic [XCOL_W-1:0] DEADBAND_RESET       = 10'd10;

  typedef enum logic [1:0] {
    STEER_STRAIGHT = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_RIGHT    = 2'd2
  } steer_t;

  typedef struct packed {
    logic [PIX_W-1:0]  threshold_low;
    logic [PIX_W-1:0]  threshold_high;
    logic [XCOL_W-1:0] split_column;
    logic [XCOL_W-1:0] camera_center_x;
    logic [XCOL_W-1:0] deadband;
  } cfg_t;

  // Totals of one finished row.
  typedef struct packed {
    logic [SUM_W-1:0] left_sum;
    logic [CNT_W-1:0] left_count;
    logic [SUM_W-1:0] right_sum;
    logic [CNT_W-1:0] right_count;
    logic             overflow;
  } row_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/core/lcs_front.sv
// Front end: classifies each pixel and accumulates per-side column sums and counts.
// Depends on lcs_pkg; hands one row_rec_t per finished row to lcs_queue.
module lcs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  lcs_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  logic [lcs_pkg::PIX_W-1:0] pixel,
  input  logic                 last_in_row,
  output logic                 push,
  output lcs_pkg::row_rec_t    rec
);

  logic [lcs_pkg::CNT_W-1:0] column, column_next;
  logic [lcs_pkg::SUM_W-1:0] left_sum, left_sum_next;
  logic [lcs_pkg::SUM_W-1:0] right_sum, right_sum_next;
  logic [lcs_pkg::CNT_W-1:0] left_count, left_count_next;
  logic [lcs_pkg::CNT_W-1:0] right_count, right_count_next;
  logic                      overflow_seen, overflow_seen_next;
  logic                      is_white;
  logic                      is_left;
  logic                      beyond;

  assign beyond   = (column == lcs_pkg::CNT_W'(lcs_pkg::MAX_WIDTH));
  assign is_white = (pixel >= cfg.threshold_low) && (pixel <= cfg.threshold_high);
  assign is_left  = (lcs_pkg::CMP_W'(column) < lcs_pkg::CMP_W'(cfg.split_column));

  always_comb begin
    column_next        = column;
    left_sum_next      = left_sum;
    right_sum_next     = right_sum;
    left_count_next    = left_count;
    right_count_next   = right_count;
    overflow_seen_next = overflow_seen;
    if (beyond) begin
      overflow_seen_next = 1'b1;
    end else begin
      column_next = column + 1'b1;
      if (is_white && is_left) begin
        left_sum_next   = left_sum + lcs_pkg::SUM_W'(column);
        left_count_next = left_count + 1'b1;
      end else if (is_white) begin
        right_sum_next   = right_sum + lcs_pkg::SUM_W'(column);
        right_count_next = right_count + 1'b1;
      end
    end
  end

  assign push             = accept && last_in_row;
  assign rec.left_sum     = left_sum_next;
  assign rec.left_count   = left_count_next;
  assign rec.right_sum    = right_sum_next;
  assign rec.right_count  = right_count_next;
  assign rec.overflow     = overflow_seen_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      column        <= '0;
      left_sum      <= '0;
      right_sum     <= '0;
      left_count    <= '0;
      right_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      column        <= column_next;
      left_sum      <= left_sum_next;
      right_sum     <= right_sum_next;
      left_count    <= left_count_next;
      right_count   <= right_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

FILE: rtl/core/lcs_queue.sv
// Short queue of finished row totals between the front end and the back end.
// Depends on lcs_pkg for the record type and depth.
module lcs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcs_pkg::row_rec_t  rec_in,
  input  logic               pop,
  output lcs_pkg::row_rec_t  head,
  output lcs_pkg::q_stat_t   stat
);

  lcs_pkg::row_rec_t          entry [lcs_pkg::QDEPTH];
  logic [lcs_pkg::QPTR_W-1:0] wr_ptr;
  logic [lcs_pkg::QPTR_W-1:0] rd_ptr;
  logic [lcs_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  function automatic logic [lcs_pkg::QPTR_W-1:0] wrap_inc(input logic [lcs_pkg::QPTR_W-1:0] p);
    if (p == lcs_pkg::QPTR_W'(lcs_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign stat.full  = (count == lcs_pkg::QCNT_W'(lcs_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/lcs_back.sv
// Back end: two bit-serial dividers for the centroids, lane center, offset and steering.
// Depends on lcs_pkg; takes rows from lcs_queue and drives the result register.
module lcs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  lcs_pkg::cfg_t                cfg,
  input  lcs_pkg::row_rec_t            head,
  input  logic                         q_empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcs_pkg::XCOL_W-1:0]   lane_center_x,
  output logic                         lanes_found,
  output logic signed [lcs_pkg::OFS_W-1:0] center_offset,
  output logic [1:0]                   steer,
  output logic                         row_overflow
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MIX,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [lcs_pkg::SUM_W-1:0] num;
    logic [lcs_pkg::SUM_W-1:0] quo;
    logic [lcs_pkg::CNT_W-1:0] rem;
  } div_t;

  state_t                      state;
  div_t                        div_l, div_r;
  div_t                        div_l_next, div_r_next;
  logic [lcs_pkg::CNT_W-1:0]   den_l, den_r;
  logic [lcs_pkg::STEP_W-1:0]  step;
  logic                        found;
  logic                        overflow;
  logic [lcs_pkg::XCOL_W-1:0]  lane;
  logic [lcs_pkg::COL_W:0]     lane_sum;
  logic [lcs_pkg::LANE_W-1:0]  lane_ext;
  logic [lcs_pkg::XCOL_W-1:0]  lane_sat;
  logic signed [lcs_pkg::OFS_W-1:0] diff;
  lcs_pkg::steer_t             steer_sel;
  logic                        out_free;

  // One restoring division step: one quotient bit per cycle.
  function automatic div_t div_step(input div_t d, input logic [lcs_pkg::CNT_W-1:0] den);
    logic [lcs_pkg::CNT_W:0] trial;
    logic                    ge;
    div_t                    r;
    trial = {d.rem, d.num[lcs_pkg::SUM_W-1]};
    ge    = (trial >= {1'b0, den});
    r.num = d.num << 1;
    r.quo = {d.quo[lcs_pkg::SUM_W-2:0], ge};
    r.rem = ge ? lcs_pkg::CNT_W'(trial - {1'b0, den}) : trial[lcs_pkg::CNT_W-1:0];
    return r;
  endfunction

  assign div_l_next = div_step(div_l, den_l);
  assign div_r_next = div_step(div_r, den_r);

  // Mean of the two centroids, clamped to the 10-bit result range.
  assign lane_sum = {1'b0, div_l.quo[lcs_pkg::COL_W-1:0]}
                  + {1'b0, div_r.quo[lcs_pkg::COL_W-1:0]};
  assign lane_ext = lcs_pkg::LANE_W'(lane_sum[lcs_pkg::COL_W:1]);
  assign lane_sat = (lane_ext > lcs_pkg::LANE_W'(lcs_pkg::XCOL_MAX))
                  ? lcs_pkg::XCOL_MAX : lane_ext[lcs_pkg::XCOL_W-1:0];

  assign diff = $signed({1'b0, cfg.camera_center_x}) - $signed({1'b0, lane});

  always_comb begin
    if (diff > 0) begin
      steer_sel = (diff[lcs_pkg::XCOL_W-1:0] < cfg.deadband)
                ? lcs_pkg::STEER_STRAIGHT : lcs_pkg::STEER_LEFT;
    end else if (diff < 0) begin
      steer_sel = lcs_pkg::STEER_RIGHT;
    end else begin
      steer_sel = lcs_pkg::STEER_STRAIGHT;
    end
  end

  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            div_l    <= '{num: head.left_sum, quo: '0, rem: '0};
            div_r    <= '{num: head.right_sum, quo: '0, rem: '0};
            den_l    <= head.left_count;
            den_r    <= head.right_count;
            found    <= (head.left_count != '0) && (head.right_count != '0);
            overflow <= head.overflow;
            step     <= lcs_pkg::STEP_W'(lcs_pkg::SUM_W - 1);
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          div_l <= div_l_next;
          div_r <= div_r_next;
          step  <= step - 1'b1;
          if (step == '0) begin
            state <= S_MIX;
          end
        end
        S_MIX: begin
          lane  <= found ? lane_sat : cfg.camera_center_x;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            lane_center_x <= lane;
            lanes_found   <= found;
            center_offset <= diff;
            steer         <= steer_sel;
            row_overflow  <= overflow;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/lane_centroid_steering_top.sv
// Top level of the lane centroid steering block: register file, front end,
// row queue and division back end. Depends on lcs_pkg, lcs_front, lcs_queue, lcs_back.
//
//   Channel   Direction  Handshake                      Payload
//   input     in         in_valid / in_stall            pixel, last_in_row
//   output    out        out_valid / out_stall          lane_center_x, lanes_found,
//                                                       center_offset, steer, row_overflow
//   config    in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// The front end takes pixel requests while the queue has room. For each row the
// back end takes the row from the queue, runs SUM_W steps of the two bit-serial
// dividers, forms the lane center and loads the result register once it is free.
// The queue holds two finished rows; when it is full in_stall rises and stays
// high until the back end takes a row. A stalled result waits in the output
// register while the back end finishes one more row, which then waits for the
// register, so only a long result stall fills the queue and reaches the front end.
// The synchronous reset rst clears
// the row totals, the queue, the back end and the result flag, and loads the
// configuration registers with their default values; no clearing pass follows.
module lane_centroid_steering_top (
  input  logic                              clk,
  input  logic                              rst,
  // Pixel requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lcs_pkg::PIX_W-1:0]         pixel,
  input  logic                              last_in_row,
  // Row results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lcs_pkg::XCOL_W-1:0]        lane_center_x,
  output logic                              lanes_found,
  output logic signed [lcs_pkg::OFS_W-1:0]  center_offset,
  output logic [1:0]                        steer,
  output logic                              row_overflow,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcs_pkg::PADDR_W-1:0]       paddr,
  input  logic [lcs_pkg::PDATA_W-1:0]       pwdata,
  output logic [lcs_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  lcs_pkg::cfg_t      cfg;
  lcs_pkg::row_rec_t  rec;
  lcs_pkg::row_rec_t  head;
  lcs_pkg::q_stat_t   q_stat;
  logic               accept;
  logic               push;
  logic               pop;
  logic               cfg_write;
  logic [2:0]         reg_sel;

  // Configuration registers. Registers sit on word addresses; the low two
  // address bits are ignored and writes beyond the last register are dropped.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_low   <= lcs_pkg::THRESHOLD_LOW_RESET;
      cfg.threshold_high  <= lcs_pkg::THRESHOLD_HIGH_RESET;
      cfg.split_column    <= lcs_pkg::SPLIT_COLUMN_RESET;
      cfg.camera_center_x <= lcs_pkg::CAMERA_CENTER_RESET;
      cfg.deadband        <= lcs_pkg::DEADBAND_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        lcs_pkg::REG_THRESHOLD_LOW:  cfg.threshold_low   <= pwdata[lcs_pkg::PIX_W-1:0];
        lcs_pkg::REG_THRESHOLD_HIGH: cfg.threshold_high  <= pwdata[lcs_pkg::PIX_W-1:0];
        lcs_pkg::REG_SPLIT_COLUMN:   cfg.split_column    <= pwdata[lcs_pkg::XCOL_W-1:0];
        lcs_pkg::REG_CAMERA_CENTER:  cfg.camera_center_x <= pwdata[lcs_pkg::XCOL_W-1:0];
        lcs_pkg::REG_DEADBAND:       cfg.deadband        <= pwdata[lcs_pkg::XCOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lcs_pkg::REG_THRESHOLD_LOW:  prdata = lcs_pkg::PDATA_W'(cfg.threshold_low);
      lcs_pkg::REG_THRESHOLD_HIGH: prdata = lcs_pkg::PDATA_W'(cfg.threshold_high);
      lcs_pkg::REG_SPLIT_COLUMN:   prdata = lcs_pkg::PDATA_W'(cfg.split_column);
      lcs_pkg::REG_CAMERA_CENTER:  prdata = lcs_pkg::PDATA_W'(cfg.camera_center_x);
      lcs_pkg::REG_DEADBAND:       prdata = lcs_pkg::PDATA_W'(cfg.deadband);
      default:                     prdata = '0;
    endcase
  end

  // A pixel is taken whenever the queue can absorb a possible row end.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  lcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .pixel       (pixel),
    .last_in_row (last_in_row),
    .push        (push),
    .rec         (rec)
  );

  lcs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .rec_in (rec),
    .pop    (pop),
    .head   (head),
    .stat   (q_stat)
  );

  lcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .q_empty       (q_stat.empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .lane_center_x (lane_center_x),
    .lanes_found   (lanes_found),
    .center_offset (center_offset),
    .steer         (steer),
    .row_overflow  (row_overflow)
  );

  // A row without both lane halves always reports a centered, straight result.
  a_not_found_straight: assert property (@(posedge clk) disable iff (rst)
    out_valid && !lanes_found |-> center_offset == '0 && steer == lcs_pkg::STEER_STRAIGHT)
    else $error("missing lane half did not give a zero offset and straight steering");

  // Turning right only ever follows a negative offset, turning left a positive one.
  a_steer_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && (steer == lcs_pkg::STEER_RIGHT || steer == lcs_pkg::STEER_LEFT)
      |-> (steer == lcs_pkg::STEER_RIGHT) == center_offset[lcs_pkg::OFS_W-1])
    else $error("steering command disagrees with the sign of the offset");

  // The queue can never look full and empty at once.
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("row queue reports full and empty together");

  // A row end is never offered to a full queue, so no row is dropped.
  a_no_lost_row: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("finished row pushed into a full queue");

endmodule
